>>> rtl/gbs_pkg.sv
package gbs_pkg;

  // One stored box: corners and area.
  typedef struct packed {
    logic [31:0] area;
    logic signed [15:0] bottom;
    logic signed [15:0] right;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } box_t;

  localparam logic [15:0] ThresholdReset = 16'd29491;

  // Extent from a to b, zero when b is not above a.
  function automatic logic [15:0] extent(input logic signed [15:0] a,
                                         input logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(b) - 17'(a);
    return (b > a) ? d[15:0] : 16'd0;
  endfunction

endpackage

>>> rtl/gbs_cell.sv
// One slot of the kept-box chain. The probe box walks past the slots in
// order; each occupied slot tests it and passes a suppress flag on.
module gbs_cell
  import gbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        load,
  input  box_t        load_box,
  input  logic [15:0] threshold,
  input  logic        in_valid,
  input  box_t        in_box,
  input  logic        in_sup,
  output logic        out_valid,
  output box_t        out_box,
  output logic        out_sup,
  output logic        occupied
);

  box_t        stored;
  logic        stage_valid;
  box_t        stage_box;
  logic        stage_sup;
  logic        stage_hit;
  logic [31:0] inter;
  logic [32:0] uni;
  logic [15:0] ix;
  logic [15:0] iy;
  logic        test_hit;

  // Stored box: written once when this slot becomes the new tail.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      occupied <= 1'b0;
    end else if (load) begin
      occupied <= 1'b1;
    end
    if (load) begin
      stored <= load_box;
    end
  end

  // Overlap extents feed one 16x16 multiply into a register.
  always_comb begin
    ix = extent((in_box.left > stored.left) ? in_box.left : stored.left,
                (in_box.right < stored.right) ? in_box.right : stored.right);
    iy = extent((in_box.top > stored.top) ? in_box.top : stored.top,
                (in_box.bottom < stored.bottom) ? in_box.bottom : stored.bottom);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= in_valid;
    end
    stage_box <= in_box;
    stage_sup <= in_sup;
    stage_hit <= occupied;
    inter     <= ix * iy;
  end

  // Second half: union and the threshold compare (16x33 multiply).
  always_comb begin
    uni      = 33'(stage_box.area) + 33'(stored.area) - 33'(inter);
    test_hit = stage_hit && ({inter, 16'd0} > 48'(threshold) * 48'(uni));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= stage_valid;
    end
    out_box <= stage_box;
    out_sup <= stage_sup | test_hit;
  end

endmodule

>>> rtl/greedy_box_suppression_unit.sv
// Greedy class-agnostic non-maximum suppression over sorted boxes. Each box
// enters a chain of MAX_KEPT cells, one per kept slot; every cell holds one
// kept box and tests the passing box in a product stage, then a compare stage.
// A box passes the input register, the cell chain and then the result register.
// Only one box is in flight at a time: the input stays closed until the result
// has been accepted, so a new request also waits while the receiver holds off
// the result. A box with final_box set clears the kept store after its result.
module greedy_box_suppression_unit
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT  = 64,
  parameter int MAX_BOXES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // left_edge, top_edge, right_edge, bottom_edge
  input  logic        s_axis_tlast,   // final_box
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // keep, box_number, store_overflow, pad
  output logic        m_axis_tlast,   // set_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CntW = $clog2(MAX_BOXES);

  logic [15:0]     threshold;
  logic            busy;
  logic            last_q;
  logic [CntW-1:0] counter;
  logic [CntW-1:0] number_q;
  box_t            new_box;
  logic [15:0]     ew;
  logic [15:0]     eh;
  logic            take;
  logic            done;
  logic            full;
  logic            head_valid;
  box_t            head_box;

  logic [MAX_KEPT:0] cv;
  logic [MAX_KEPT:0] cs;
  box_t              cb [MAX_KEPT+1];
  logic [MAX_KEPT-1:0] occ;
  logic [MAX_KEPT-1:0] load;
  logic [MAX_KEPT-1:0] tail;

  assign cfg_ready     = 1'b1;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThresholdReset;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  // Probe box with its area, formed at the input.
  always_comb begin
    new_box.left   = s_axis_tdata[15:0];
    new_box.top    = s_axis_tdata[31:16];
    new_box.right  = s_axis_tdata[47:32];
    new_box.bottom = s_axis_tdata[63:48];
    ew = extent(new_box.left, new_box.right);
    eh = extent(new_box.top, new_box.bottom);
    new_box.area = ew * eh;
  end

  always_ff @(posedge clk) begin
    head_valid <= take && !rst;
    head_box   <= new_box;
  end

  assign cv[0] = head_valid;
  assign cb[0] = head_box;
  assign cs[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_KEPT; g++) begin : g_cell
      // First empty slot is the tail where a kept box goes.
      if (g == 0) begin : g_t0
        assign tail[g] = !occ[g];
      end else begin : g_tn
        assign tail[g] = !occ[g] && occ[g-1];
      end
      assign load[g] = done && !cs[MAX_KEPT] && tail[g];
      gbs_cell u_cell (
        .clk(clk), .rst(rst), .clear(done && last_q), .load(load[g]),
        .load_box(cb[MAX_KEPT]), .threshold(threshold),
        .in_valid(cv[g]), .in_box(cb[g]), .in_sup(cs[g]),
        .out_valid(cv[g+1]), .out_box(cb[g+1]), .out_sup(cs[g+1]),
        .occupied(occ[g])
      );
    end
  endgenerate

  assign done = cv[MAX_KEPT];
  assign full = occ[MAX_KEPT-1];

  // Sequencing of one box and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      counter       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (take) begin
        busy     <= 1'b1;
        last_q   <= s_axis_tlast;
        number_q <= counter;
        if (s_axis_tlast || counter == CntW'(MAX_BOXES - 1)) begin
          counter <= '0;
        end else begin
          counter <= counter + 1'b1;
        end
      end
      if (done) begin
        busy          <= 1'b0;
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {2'b00, !cs[MAX_KEPT] && full, 12'(number_q),
                          !cs[MAX_KEPT] && !full};
        m_axis_tlast  <= last_q;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Slots fill from the front without gaps.
  a_fill : assert property (@(posedge clk) disable iff (rst)
    $onehot0(tail))
    else $error("kept slots are not contiguous");
  a_single : assert property (@(posedge clk) disable iff (rst)
    $countones(cv) <= 1)
    else $error("more than one box in the chain");
  a_done : assert property (@(posedge clk) disable iff (rst)
    done |=> m_axis_tvalid)
    else $error("result lost");

endmodule
